// ===== rtl/core/traffic_light_pixel_classifier_macros.svh =====
// Assertion macros for the traffic light pixel classifier.
// Used by the top level; no other dependencies.
`ifndef TRAFFIC_LIGHT_PIXEL_CLASSIFIER_MACROS_SVH
`define TRAFFIC_LIGHT_PIXEL_CLASSIFIER_MACROS_SVH

`ifndef ASSERT_OFF
// prop must hold at every clock edge out of reset
`define TLPC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// when ante holds, cons must hold at the next clock edge
`define TLPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TLPC_ASSERT(label, clk, rst_n, prop, msg)
`define TLPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/core/tlpc_pkg.sv =====
// Shared constants and types of the traffic light pixel classifier.
// No dependencies.
`default_nettype none

package tlpc_pkg;

  // field widths
  localparam int unsigned PixW   = 8;
  localparam int unsigned DepthW = 16;
  localparam int unsigned CfgW   = 13;
  localparam int unsigned TotalW = 24;
  localparam int unsigned MeanW  = 16;

  // defaults for the top-level parameters
  localparam int unsigned DefMaxWidth  = 4096;
  localparam int unsigned DefCountBits = 24;

  // reset value of the mask start register, given by an image width
  localparam int unsigned WidthReset = 640;
  localparam int unsigned StartReset = WidthReset - (WidthReset * 2) / 3;

  // x / 3 as (x * 21846) >> 16, exact for x below 2^14
  localparam int unsigned Recip3      = 21846;
  localparam int unsigned Recip3W     = 15;
  localparam int unsigned Recip3Shift = 16;

  // grey conversion of the label pixel
  localparam int unsigned GreyW     = 22;
  localparam int unsigned GreyShift = 14;
  localparam int unsigned GreyCoefB = 1868;
  localparam int unsigned GreyCoefG = 9617;
  localparam int unsigned GreyCoefR = 4899;
  localparam int unsigned GreyRound = 8192;
  localparam int unsigned GreyLimit = 210;

  // color decision margins
  localparam int RedMargin   = 110;
  localparam int GreenMargin = 150;

  // frame verdict
  localparam int unsigned GreenMinCount = 5;
  localparam int unsigned RedMinCount   = 1;
  localparam int unsigned StopDistance  = 20000;
  localparam int unsigned NoRedDistance = 255;

  // queue between front and back
  localparam int unsigned FifoDepth = 2;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_RESULT
  } back_state_e;

endpackage

`default_nettype wire

// ===== rtl/core/tlpc_if.sv =====
// Handshake channels of the classifier: pixel input and frame result.
// Depends on tlpc_pkg for field widths.
`default_nettype none

interface tlpc_in_if import tlpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PixW-1:0]   sem_blue;
  logic [PixW-1:0]   sem_green;
  logic [PixW-1:0]   sem_red;
  logic [PixW-1:0]   cam_blue;
  logic [PixW-1:0]   cam_green;
  logic [PixW-1:0]   cam_red;
  logic [DepthW-1:0] depth_value;
  logic              end_of_row;
  logic              last_in_frame;

  modport source (
    output valid, sem_blue, sem_green, sem_red, cam_blue, cam_green, cam_red,
           depth_value, end_of_row, last_in_frame,
    input  ready
  );
  modport sink (
    input  valid, sem_blue, sem_green, sem_red, cam_blue, cam_green, cam_red,
           depth_value, end_of_row, last_in_frame,
    output ready
  );
endinterface

interface tlpc_out_if import tlpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              is_red;
  logic              stop_request;
  logic [MeanW-1:0]  mean_distance;
  logic [TotalW-1:0] red_total;
  logic [TotalW-1:0] green_total;

  modport source (
    output valid, is_red, stop_request, mean_distance, red_total, green_total,
    input  ready
  );
  modport sink (
    input  valid, is_red, stop_request, mean_distance, red_total, green_total,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/traffic_light_pixel_classifier.sv =====
// Traffic light pixel classifier, top level.
// Throughput: one pixel per cycle; input stalls only while the queue holds two frames.
// The frame result follows its last accepted pixel through the queue, a pop from
// the idle state, the bit-serial mean divider and the result register.
// Reset: asynchronous, active low; clears counts, column, queue and result valid,
// and the mask start returns to its value for an image width of 640.
`default_nettype none

`include "traffic_light_pixel_classifier_macros.svh"

module traffic_light_pixel_classifier import tlpc_pkg::*; #(
  parameter int unsigned MaxWidth  = DefMaxWidth,
  parameter int unsigned CountBits = DefCountBits
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i,
  tlpc_in_if.sink              pix_i,
  tlpc_out_if.source           res_o
);

  localparam int unsigned StatW = 3 * CountBits + DepthW;

  logic             push, pop, full, empty;
  logic [StatW-1:0] stat_in, stat_out;

  tlpc_front #(
    .MaxWidth  (MaxWidth),
    .CountBits (CountBits),
    .StatW     (StatW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_i),
    .full_i      (full),
    .push_o      (push),
    .stat_o      (stat_in)
  );

  tlpc_fifo #(
    .DataW (StatW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (stat_in),
    .pop_i   (pop),
    .data_o  (stat_out),
    .full_o  (full),
    .empty_o (empty)
  );

  tlpc_back #(
    .CountBits (CountBits),
    .StatW     (StatW)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .data_i  (stat_out),
    .pop_o   (pop),
    .res_o   (res_o)
  );

  `TLPC_ASSERT(a_no_push_full, clk_i, rst_ni, !(push && full), "frame pushed into full queue")
  `TLPC_ASSERT(a_no_pop_empty, clk_i, rst_ni, !(pop && empty), "pop from empty queue")
  `TLPC_ASSERT_NEXT(a_push_visible, clk_i, rst_ni, push, !empty, "pushed frame lost")

endmodule

`default_nettype wire

// ===== rtl/core/tlpc_front.sv =====
// Front end: accepts pixels, classifies them and accumulates frame counts.
// Pushes one statistics word per frame. Depends on tlpc_pkg and tlpc_if.
`default_nettype none

module tlpc_front import tlpc_pkg::*; #(
  parameter int unsigned MaxWidth  = DefMaxWidth,
  parameter int unsigned CountBits = DefCountBits,
  parameter int unsigned StatW     = 3 * CountBits + DepthW
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CfgW-1:0]  cfg_wdata_i,
  tlpc_in_if.sink               pix_i,
  input  wire logic             full_i,
  output logic                  push_o,
  output logic [StatW-1:0]      stat_o
);

  localparam int unsigned ColW  = $clog2(MaxWidth);
  localparam int unsigned CmpW  = (ColW > CfgW) ? ColW : CfgW;
  localparam int unsigned SumW  = CountBits + DepthW;
  localparam int unsigned ProdW = CfgW + 1 + Recip3W;

  logic [CfgW-1:0]      start_q;
  logic [ColW-1:0]      col_q, col_d;
  logic [CountBits-1:0] red_q, red_d, green_q, green_d;
  logic [SumW-1:0]      sum_q, sum_d;

  logic [CfgW:0]        dbl_width;
  logic [ProdW-1:0]     third_prod;
  logic [CfgW-1:0]      start_d;
  logic [GreyW-1:0]     grey_sum;
  logic [PixW-1:0]      grey;
  logic signed [PixW:0] red_minus_green, green_minus_red;
  logic                 in_region, masked, is_red_pix, is_green_pix, accept;

  // mask start = width - (2*width)/3
  assign dbl_width  = {cfg_wdata_i, 1'b0};
  assign third_prod = ProdW'(dbl_width) * ProdW'(Recip3);
  assign start_d    = cfg_wdata_i - third_prod[Recip3Shift +: CfgW];

  assign grey_sum = GreyW'(GreyCoefB) * GreyW'(pix_i.sem_blue)
                  + GreyW'(GreyCoefG) * GreyW'(pix_i.sem_green)
                  + GreyW'(GreyCoefR) * GreyW'(pix_i.sem_red)
                  + GreyW'(GreyRound);
  assign grey = grey_sum[GreyShift +: PixW];

  assign red_minus_green = signed'({1'b0, pix_i.cam_red}) - signed'({1'b0, pix_i.cam_green});
  assign green_minus_red = signed'({1'b0, pix_i.cam_green}) - signed'({1'b0, pix_i.cam_red});
  assign is_red_pix      = red_minus_green > RedMargin;
  assign is_green_pix    = green_minus_red > GreenMargin;

  assign in_region = CmpW'(col_q) >= CmpW'(start_q);
  assign masked    = in_region && (grey > PixW'(GreyLimit));

  assign pix_i.ready = !full_i;
  assign accept      = pix_i.valid && pix_i.ready;

  always_comb begin
    red_d   = red_q;
    green_d = green_q;
    sum_d   = sum_q;
    if (masked) begin
      if (is_red_pix) begin
        if (red_q != '1) begin
          red_d = red_q + 1'b1;
          sum_d = sum_q + SumW'(pix_i.depth_value);
        end
      end else if (is_green_pix) begin
        if (green_q != '1) begin
          green_d = green_q + 1'b1;
        end
      end
    end
    if (pix_i.end_of_row || pix_i.last_in_frame) begin
      col_d = '0;
    end else if (col_q < ColW'(MaxWidth - 1)) begin
      col_d = col_q + 1'b1;
    end else begin
      col_d = col_q;
    end
  end

  // the frame's last pixel is counted in the pushed word
  assign push_o = accept && pix_i.last_in_frame;
  assign stat_o = {red_d, green_d, sum_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= CfgW'(StartReset);
      col_q   <= '0;
      red_q   <= '0;
      green_q <= '0;
      sum_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        start_q <= start_d;
      end
      if (accept) begin
        col_q <= col_d;
        if (pix_i.last_in_frame) begin
          red_q   <= '0;
          green_q <= '0;
          sum_q   <= '0;
        end else begin
          red_q   <= red_d;
          green_q <= green_d;
          sum_q   <= sum_d;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tlpc_fifo.sv =====
// Short queue of frame statistics between front and back end.
// Depends on tlpc_pkg for its depth.
`default_nettype none

module tlpc_fifo import tlpc_pkg::*; #(
  parameter int unsigned DataW = 3 * DefCountBits + DepthW
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [DataW-1:0] data_i,
  input  wire logic             pop_i,
  output logic      [DataW-1:0] data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  logic [DataW-1:0] entry_q [FifoDepth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(FifoDepth);
  assign empty_o = cnt_q == '0;
  assign data_o  = entry_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(FifoDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tlpc_back.sv =====
// Back end: takes frame statistics, divides depth sum by red count one
// quotient bit per cycle, forms the verdict and holds the result item.
// Depends on tlpc_pkg and tlpc_if.
`default_nettype none

module tlpc_back import tlpc_pkg::*; #(
  parameter int unsigned CountBits = DefCountBits,
  parameter int unsigned StatW     = 3 * CountBits + DepthW
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             empty_i,
  input  wire logic [StatW-1:0] data_i,
  output logic                  pop_o,
  tlpc_out_if.source            res_o
);

  localparam int unsigned SumW  = CountBits + DepthW;
  localparam int unsigned StepW = $clog2(MeanW);

  back_state_e state_q, state_d;

  logic [CountBits-1:0] red_q, green_q, rem_q, rem_d;
  logic [MeanW-1:0]     quo_q, quo_d;
  logic [StepW-1:0]     step_q;
  logic [CountBits:0]   trial, trial_diff;
  logic                 trial_ge, div_en, load_res, last_step;

  logic                 valid_q, is_red_q, stop_q;
  logic [MeanW-1:0]     mean_q;
  logic [TotalW-1:0]    red_tot_q, green_tot_q;

  logic                 green_wins, red_verdict;
  logic [MeanW-1:0]     mean;
  logic [CountBits+TotalW-1:0] red_ext, green_ext;

  assign last_step = step_q == StepW'(MeanW - 1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:   if (!empty_i) state_d = BK_DIVIDE;
      BK_DIVIDE: if (last_step) state_d = BK_RESULT;
      BK_RESULT: if (!valid_q || res_o.ready) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o    = 1'b0;
    div_en   = 1'b0;
    load_res = 1'b0;
    unique case (state_q)
      BK_IDLE:   pop_o    = !empty_i;
      BK_DIVIDE: div_en   = 1'b1;
      BK_RESULT: load_res = !valid_q || res_o.ready;
      default:   ;
    endcase
  end

  // restoring division step; the partial remainder stays below the count
  assign trial      = {rem_q, quo_q[MeanW-1]};
  assign trial_diff = trial - {1'b0, red_q};
  assign trial_ge   = trial >= {1'b0, red_q};
  assign rem_d      = trial_ge ? trial_diff[CountBits-1:0] : trial[CountBits-1:0];
  assign quo_d      = {quo_q[MeanW-2:0], trial_ge};

  assign green_wins  = (green_q > CountBits'(GreenMinCount)) && (green_q > red_q);
  assign red_verdict = !green_wins && (red_q > CountBits'(RedMinCount)) && (red_q > green_q);
  assign mean        = (red_q == '0) ? MeanW'(NoRedDistance) : quo_q;
  assign red_ext     = (CountBits + TotalW)'(red_q);
  assign green_ext   = (CountBits + TotalW)'(green_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        step_q <= '0;
      end else if (div_en) begin
        step_q <= step_q + 1'b1;
      end
      if (load_res) begin
        valid_q <= 1'b1;
      end else if (res_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      red_q   <= data_i[SumW + CountBits +: CountBits];
      green_q <= data_i[SumW +: CountBits];
      rem_q   <= data_i[MeanW +: CountBits];
      quo_q   <= data_i[MeanW-1:0];
    end else if (div_en) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (load_res) begin
      is_red_q    <= red_verdict;
      stop_q      <= red_verdict && (mean < MeanW'(StopDistance));
      mean_q      <= mean;
      red_tot_q   <= red_ext[TotalW-1:0];
      green_tot_q <= green_ext[TotalW-1:0];
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.is_red        = is_red_q;
  assign res_o.stop_request  = stop_q;
  assign res_o.mean_distance = mean_q;
  assign res_o.red_total     = red_tot_q;
  assign res_o.green_total   = green_tot_q;

endmodule

`default_nettype wire
